// File: rtl/fbls_pkg.sv
// ----------------------------------------------------------------------------
// fbls_pkg: shared types and constants of the fade / blink light sequencer
// Field widths, fixed-point constants, phase and command codes, unit controls.
// ----------------------------------------------------------------------------
`default_nettype none

package fbls_pkg;

    localparam int COLOR_W   = 32;
    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = COLOR_W / CHAN_W;
    localparam int GLOW_W    = 17;
    localparam int FRAC_W    = 16;
    localparam int TIME_W    = 16;
    localparam int PHASE_W   = 2;
    localparam int FUNC_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    // Q1.16 one and one half
    localparam logic [GLOW_W-1:0] Q_ONE  = 17'h10000;
    localparam logic [GLOW_W-1:0] Q_HALF = 17'h08000;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE  = 2'd0,
        PH_IN    = 2'd1,
        PH_BLINK = 2'd2,
        PH_OUT   = 2'd3
    } phase_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK  = 2'd0,
        FN_BEGIN = 2'd1,
        FN_END   = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FADE_TICKS   = 2'd0,
        CFG_BLINK_PERIOD = 2'd1,
        CFG_REST_COLOR   = 2'd2,
        CFG_LIT_COLOR    = 2'd3
    } cfg_idx_t;

    // divider command: start pulse, and fraction mode (16 steps) vs modulo (17 steps)
    typedef struct packed {
        logic start;
        logic frac_mode;
    } div_ctl_t;

endpackage

`default_nettype wire

// File: rtl/fbls_div.sv
// ----------------------------------------------------------------------------
// fbls_div: bit-serial restoring divider
// One quotient bit per cycle. Remainder starts at hi (must be below den),
// bits of lo shift in MSB first. Modulo mode runs 17 steps, fraction 16.
// ----------------------------------------------------------------------------
`default_nettype none

module fbls_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire fbls_pkg::div_ctl_t           ctl,
    input  wire logic [fbls_pkg::FRAC_W-1:0]  hi,
    input  wire logic [fbls_pkg::FRAC_W:0]    lo,
    input  wire logic [fbls_pkg::FRAC_W-1:0]  den,
    output logic                              done,
    output logic [fbls_pkg::FRAC_W-1:0]       rem,
    output logic [fbls_pkg::FRAC_W-1:0]       quo
);
    import fbls_pkg::*;

    localparam int CNT_W = $clog2(FRAC_W + 2);

    logic [FRAC_W-1:0] rem_reg, rem_next;
    logic [FRAC_W:0]   lo_reg, lo_next;
    logic [FRAC_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              done_reg, done_next;

    logic [FRAC_W:0]   trial;
    logic [FRAC_W:0]   diff;
    logic              ge;

    always_comb begin
        trial = {rem_reg, lo_reg[FRAC_W]};
        diff  = trial - {1'b0, den};
        ge    = (trial >= {1'b0, den});

        rem_next  = rem_reg;
        lo_next   = lo_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;

        if (ctl.start) begin
            rem_next = hi;
            lo_next  = lo;
            quo_next = '0;
            cnt_next = ctl.frac_mode ? CNT_W'(FRAC_W) : CNT_W'(FRAC_W + 1);
        end else if (cnt_reg != '0) begin
            rem_next  = ge ? diff[FRAC_W-1:0] : trial[FRAC_W-1:0];
            lo_next   = {lo_reg[FRAC_W-1:0], 1'b0};
            quo_next  = {quo_reg[FRAC_W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

// File: rtl/fbls_lerp.sv
// ----------------------------------------------------------------------------
// fbls_lerp: bit-serial linear interpolation, four color lanes and one glow lane
// Each lane accumulates (end - start) * t, one bit of t per cycle MSB first,
// then adds start plus the rounding half and keeps the integer part; t is Q1.16.
// ----------------------------------------------------------------------------
`default_nettype none

module fbls_lerp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [fbls_pkg::GLOW_W-1:0]   t,
    input  wire logic [fbls_pkg::COLOR_W-1:0]  s_color,
    input  wire logic [fbls_pkg::COLOR_W-1:0]  e_color,
    input  wire logic [fbls_pkg::GLOW_W-1:0]   s_glow,
    input  wire logic [fbls_pkg::GLOW_W-1:0]   e_glow,
    output logic                               done,
    output logic [fbls_pkg::COLOR_W-1:0]       color,
    output logic [fbls_pkg::GLOW_W-1:0]        glow
);
    import fbls_pkg::*;

    localparam int CNT_W  = $clog2(GLOW_W + 1);
    localparam int CD_W   = CHAN_W + 1;        // color difference, two's complement
    localparam int GD_W   = GLOW_W + 1;        // glow difference
    localparam int CACC_W = CHAN_W + GLOW_W;   // |d*t| < 2^24
    localparam int GACC_W = 2 * GLOW_W;        // |d*t| <= 2^32

    logic [GLOW_W-1:0]  t_reg, t_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [COLOR_W-1:0] sc_reg, sc_next;
    logic [GLOW_W-1:0]  sg_reg, sg_next;
    logic [CD_W-1:0]    dc_reg [NUM_CHAN];
    logic [CD_W-1:0]    dc_next [NUM_CHAN];
    logic [CACC_W-1:0]  ac_reg [NUM_CHAN];
    logic [CACC_W-1:0]  ac_next [NUM_CHAN];
    logic [GD_W-1:0]    dg_reg, dg_next;
    logic [GACC_W-1:0]  ag_reg, ag_next;

    logic [CACC_W-1:0]  c_round [NUM_CHAN];
    logic [GACC_W-1:0]  g_round;

    always_comb begin
        t_next    = t_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        sc_next   = sc_reg;
        sg_next   = sg_reg;
        dg_next   = dg_reg;
        ag_next   = ag_reg;
        for (int i = 0; i < NUM_CHAN; i++) begin
            dc_next[i] = dc_reg[i];
            ac_next[i] = ac_reg[i];
        end

        if (start) begin
            t_next   = t;
            cnt_next = CNT_W'(GLOW_W);
            sc_next  = s_color;
            sg_next  = s_glow;
            dg_next  = {1'b0, e_glow} - {1'b0, s_glow};
            ag_next  = '0;
            for (int i = 0; i < NUM_CHAN; i++) begin
                dc_next[i] = {1'b0, e_color[i*CHAN_W +: CHAN_W]}
                           - {1'b0, s_color[i*CHAN_W +: CHAN_W]};
                ac_next[i] = '0;
            end
        end else if (cnt_reg != '0) begin
            // acc = 2*acc + (t bit ? d : 0), sign-extended by hand
            for (int i = 0; i < NUM_CHAN; i++) begin
                ac_next[i] = {ac_reg[i][CACC_W-2:0], 1'b0}
                           + (t_reg[GLOW_W-1]
                              ? {{(CACC_W-CD_W){dc_reg[i][CD_W-1]}}, dc_reg[i]}
                              : CACC_W'(0));
            end
            ag_next = {ag_reg[GACC_W-2:0], 1'b0}
                    + (t_reg[GLOW_W-1]
                       ? {{(GACC_W-GD_W){dg_reg[GD_W-1]}}, dg_reg}
                       : GACC_W'(0));
            t_next    = {t_reg[GLOW_W-2:0], 1'b0};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    // start + floor((d*t + half) / 2^16): bits above FRAC_W are the floor
    always_comb begin
        for (int i = 0; i < NUM_CHAN; i++) begin
            c_round[i] = ac_reg[i] + CACC_W'(Q_HALF);
            color[i*CHAN_W +: CHAN_W] = sc_reg[i*CHAN_W +: CHAN_W]
                                      + c_round[i][FRAC_W +: CHAN_W];
        end
        g_round = ag_reg + GACC_W'(Q_HALF);
        glow    = sg_reg + g_round[FRAC_W +: GLOW_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        t_reg  <= t_next;
        sc_reg <= sc_next;
        sg_reg <= sg_next;
        dg_reg <= dg_next;
        ag_reg <= ag_next;
        for (int i = 0; i < NUM_CHAN; i++) begin
            dc_reg[i] <= dc_next[i];
            ac_reg[i] <= ac_next[i];
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// File: rtl/fade_blink_light_sequencer.sv
// ----------------------------------------------------------------------------
// fade_blink_light_sequencer: four-phase light sequencer (idle, fade in,
// blink, fade out) with bit-serial divide and interpolate units
// ----------------------------------------------------------------------------
//
//  channel | direction | beat contents (low bits first)
//  --------+-----------+--------------------------------------------------
//  cfg     | in        | cfg_index = register, cfg_data = value
//  s_      | in        | tuser = func[1:0], tdata = delta_time[15:0]
//  m_      | out       | tdata = color_out[31:0], glow_out[48:32],
//          |           |         phase_out[50:49], zero pad [55:51]
//
//  Sequence: a fading tick runs a timer check, a 16-step serial divide for
//  fade progress, then a 17-step serial lerp; once the timer has reached
//  the fade length the divide is skipped. A blinking tick runs a 17-step
//  modulo, then a 16-step fraction divide on the same divider; any other
//  beat goes straight to the output. s_tready returns as the result is
//  loaded into the m_ register. One beat is in flight at a time.
//  Reset: synchronous, active low; all registers but t, sum and m_tdata reset.
//  Stalls: a finished result sits in the m_ output register; the next s_
//  beat is taken meanwhile and its result waits for that register to free.
//
`default_nettype none

module fade_blink_light_sequencer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [fbls_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [fbls_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [fbls_pkg::TIME_W-1:0]        s_tdata,   // delta_time
    input  wire logic [fbls_pkg::FUNC_W-1:0]        s_tuser,   // func

    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // color_out [31:0], glow_out [48:32], phase_out [50:49], zero pad above
    output logic [((fbls_pkg::COLOR_W + fbls_pkg::GLOW_W + fbls_pkg::PHASE_W + 7) / 8) * 8 - 1:0]
                                                    m_tdata
);
    import fbls_pkg::*;

    localparam int OUT_BITS = COLOR_W + GLOW_W + PHASE_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_READY,
        ST_FADE_START,
        ST_FADE_DIV,
        ST_FADE_LERP,
        ST_BLINK_MOD,
        ST_BLINK_FRAC,
        ST_EMIT
    } state_t;

    // control
    state_t             state_reg, state_next;
    phase_t             phase_reg, phase_next;
    div_ctl_t           div_ctl_reg, div_ctl_next;
    logic               lerp_start_reg, lerp_start_next;
    logic               m_tvalid_reg, m_tvalid_next;

    // configuration
    logic [TIME_W-1:0]  fade_ticks_reg, fade_ticks_next;
    logic [TIME_W-1:0]  blink_period_reg, blink_period_next;
    logic [COLOR_W-1:0] rest_color_reg, rest_color_next;
    logic [COLOR_W-1:0] lit_color_reg, lit_color_next;

    // sequencer state
    logic [TIME_W-1:0]  fade_timer_reg, fade_timer_next;
    logic [TIME_W-1:0]  blink_pos_reg, blink_pos_next;
    logic [COLOR_W-1:0] color_reg, color_next;
    logic [GLOW_W-1:0]  glow_reg, glow_next;
    logic [COLOR_W-1:0] start_color_reg, start_color_next;
    logic [GLOW_W-1:0]  start_glow_reg, start_glow_next;

    // work registers
    logic [GLOW_W-1:0]  t_reg, t_next;       // fade progress, Q1.16
    logic [TIME_W:0]    sum_reg, sum_next;   // blink position + delta
    logic [OUT_W-1:0]   m_tdata_reg, m_tdata_next;

    // unit hookup
    logic [FRAC_W-1:0]  div_hi;
    logic [FRAC_W:0]    div_lo;
    logic [FRAC_W-1:0]  div_den;
    logic               div_done;
    logic [FRAC_W-1:0]  div_rem;
    logic [FRAC_W-1:0]  div_quo;
    logic               lerp_done;
    logic [COLOR_W-1:0] lerp_color;
    logic [GLOW_W-1:0]  lerp_glow;
    logic [COLOR_W-1:0] end_color;
    logic [GLOW_W-1:0]  end_glow;

    logic               s_accept;
    logic [TIME_W:0]    timer_sum;
    logic [GLOW_W-1:0]  two_u;
    logic [GLOW_W:0]    tri_down;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_READY);
    assign cfg_ready = 1'b1;

    // operands follow the state in which the start pulse lands
    always_comb begin
        div_hi = '0;
        div_lo = '0;
        unique case (state_reg)
            ST_FADE_DIV:   div_hi = fade_timer_reg;
            ST_BLINK_MOD:  div_lo = sum_reg;
            ST_BLINK_FRAC: div_hi = blink_pos_reg;
            default: ;
        endcase
        if (state_reg == ST_FADE_DIV) begin
            div_den = fade_ticks_reg;
        end else begin
            // a zero period behaves as a period of one
            div_den = (blink_period_reg == '0) ? TIME_W'(1) : blink_period_reg;
        end
    end

    // fade in heads for the lit color at full glow, fade out for rest and dark
    assign end_color = (phase_reg == PH_IN) ? lit_color_reg : rest_color_reg;
    assign end_glow  = (phase_reg == PH_IN) ? Q_ONE : GLOW_W'(0);

    fbls_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (div_ctl_reg),
        .hi      (div_hi),
        .lo      (div_lo),
        .den     (div_den),
        .done    (div_done),
        .rem     (div_rem),
        .quo     (div_quo)
    );

    fbls_lerp u_lerp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lerp_start_reg),
        .t       (t_reg),
        .s_color (start_color_reg),
        .e_color (end_color),
        .s_glow  (start_glow_reg),
        .e_glow  (end_glow),
        .done    (lerp_done),
        .color   (lerp_color),
        .glow    (lerp_glow)
    );

    always_comb begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        div_ctl_next      = '0;
        lerp_start_next   = 1'b0;
        m_tvalid_next     = m_tvalid_reg;
        fade_ticks_next   = fade_ticks_reg;
        blink_period_next = blink_period_reg;
        rest_color_next   = rest_color_reg;
        lit_color_next    = lit_color_reg;
        fade_timer_next   = fade_timer_reg;
        blink_pos_next    = blink_pos_reg;
        color_next        = color_reg;
        glow_next         = glow_reg;
        start_color_next  = start_color_reg;
        start_glow_next   = start_glow_reg;
        t_next            = t_reg;
        sum_next          = sum_reg;
        m_tdata_next      = m_tdata_reg;

        timer_sum = {1'b0, fade_timer_reg} + {1'b0, s_tdata};
        two_u     = {div_quo, 1'b0};
        tri_down  = {2'b10, {FRAC_W{1'b0}}} - {1'b0, two_u};   // 2.0 - 2u

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_FADE_TICKS:   fade_ticks_next   = cfg_data[TIME_W-1:0];
                CFG_BLINK_PERIOD: blink_period_next = cfg_data[TIME_W-1:0];
                CFG_REST_COLOR:   rest_color_next   = cfg_data[COLOR_W-1:0];
                CFG_LIT_COLOR:    lit_color_next    = cfg_data[COLOR_W-1:0];
            endcase
        end

        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_READY: begin
                if (s_accept) begin
                    state_next = ST_EMIT;
                    unique case (func_t'(s_tuser))
                        FN_TICK: begin
                            unique case (phase_reg) inside
                                PH_IN, PH_OUT: begin
                                    // timer saturates at all ones
                                    fade_timer_next = timer_sum[TIME_W] ? '1
                                                    : timer_sum[TIME_W-1:0];
                                    state_next      = ST_FADE_START;
                                end
                                PH_BLINK: begin
                                    sum_next           = {1'b0, blink_pos_reg}
                                                       + {1'b0, s_tdata};
                                    div_ctl_next.start = 1'b1;
                                    state_next         = ST_BLINK_MOD;
                                end
                                default: ;
                            endcase
                        end
                        FN_BEGIN: begin
                            if (phase_reg == PH_IDLE || phase_reg == PH_OUT) begin
                                fade_timer_next  = '0;
                                phase_next       = PH_IN;
                                start_color_next = color_reg;
                                start_glow_next  = glow_reg;
                            end
                        end
                        FN_END: begin
                            if (phase_reg == PH_IN || phase_reg == PH_BLINK) begin
                                fade_timer_next  = '0;
                                phase_next       = PH_OUT;
                                start_color_next = color_reg;
                                start_glow_next  = glow_reg;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_FADE_START: begin
                if (fade_timer_reg >= fade_ticks_reg) begin
                    t_next          = Q_ONE;
                    lerp_start_next = 1'b1;
                    state_next      = ST_FADE_LERP;
                end else begin
                    div_ctl_next.start     = 1'b1;
                    div_ctl_next.frac_mode = 1'b1;
                    state_next             = ST_FADE_DIV;
                end
            end

            ST_FADE_DIV: begin
                if (div_done) begin
                    t_next          = {1'b0, div_quo};
                    lerp_start_next = 1'b1;
                    state_next      = ST_FADE_LERP;
                end
            end

            ST_FADE_LERP: begin
                if (lerp_done) begin
                    color_next = lerp_color;
                    glow_next  = lerp_glow;
                    if (t_reg == Q_ONE) begin
                        if (phase_reg == PH_IN) begin
                            phase_next     = PH_BLINK;
                            blink_pos_next = '0;
                        end else begin
                            phase_next = PH_IDLE;
                        end
                    end
                    state_next = ST_EMIT;
                end
            end

            ST_BLINK_MOD: begin
                if (div_done) begin
                    blink_pos_next         = div_rem;
                    div_ctl_next.start     = 1'b1;
                    div_ctl_next.frac_mode = 1'b1;
                    state_next             = ST_BLINK_FRAC;
                end
            end

            ST_BLINK_FRAC: begin
                if (div_done) begin
                    // triangle: rising half 2u, falling half 2 - 2u
                    glow_next  = div_quo[FRAC_W-1] ? tri_down[GLOW_W-1:0] : two_u;
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = OUT_W'({phase_reg, glow_reg, color_reg});
                    m_tvalid_next = 1'b1;
                    state_next    = ST_READY;
                end
            end

            default: state_next = ST_READY;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_READY;
            phase_reg        <= PH_IDLE;
            div_ctl_reg      <= '0;
            lerp_start_reg   <= 1'b0;
            m_tvalid_reg     <= 1'b0;
            fade_ticks_reg   <= TIME_W'(1000);
            blink_period_reg <= TIME_W'(1000);
            rest_color_reg   <= '0;
            lit_color_reg    <= '1;
            fade_timer_reg   <= '0;
            blink_pos_reg    <= '0;
            color_reg        <= '0;
            glow_reg         <= '0;
            start_color_reg  <= '0;
            start_glow_reg   <= '0;
        end else begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            div_ctl_reg      <= div_ctl_next;
            lerp_start_reg   <= lerp_start_next;
            m_tvalid_reg     <= m_tvalid_next;
            fade_ticks_reg   <= fade_ticks_next;
            blink_period_reg <= blink_period_next;
            rest_color_reg   <= rest_color_next;
            lit_color_reg    <= lit_color_next;
            fade_timer_reg   <= fade_timer_next;
            blink_pos_reg    <= blink_pos_next;
            color_reg        <= color_next;
            glow_reg         <= glow_next;
            start_color_reg  <= start_color_next;
            start_glow_reg   <= start_glow_next;
        end
        t_reg       <= t_next;
        sum_reg     <= sum_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// File: tb/fade_blink_light_sequencer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fade_blink_light_sequencer_tb: self-checking bench for the light sequencer
// A directed table walks every command and the corner cases of fade and
// blink. Random traffic that follows the phase of the sequencer then runs
// under several register settings. Every result beat is compared with an
// in-bench model of the colour, glow and phase, or with a hand-written value.
// ----------------------------------------------------------------------------
module fade_blink_light_sequencer_tb;
    import fbls_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 10;
    localparam int QUIET_LIMIT  = 4000;  // cycles with no handshake on any channel
    localparam int SETTLE_CYCLES = 60;   // tail after the last result, > one tick
    localparam int HOLD_AFTER   = 200;   // results seen before the long sink stall
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BEATS = 138;   // effective beats per register setting
    localparam int MAX_PRINTS   = 50;
    localparam int M_W = ((COLOR_W + GLOW_W + PHASE_W + 7) / 8) * 8;

    // command code outside func_t; the block must treat it as a no-op
    localparam logic [FUNC_W-1:0] FN_NONE = 2'd3;

    typedef struct {
        logic [COLOR_W-1:0] color;
        logic [GLOW_W-1:0]  glow;
        phase_t             ph;
    } light_t;

    typedef struct {
        bit                    is_write;
        cfg_idx_t              idx;
        logic [CFG_DATA_W-1:0] val;
        logic [FUNC_W-1:0]     fn;
        logic [TIME_W-1:0]     dt;
        bit                    typed;   // want holds a hand-written result
        light_t                want;
    } stim_row_t;

    typedef enum int {
        READY_ALWAYS,
        READY_COIN,
        READY_MOSTLY,
        READY_COMB
    } ready_mode_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [TIME_W-1:0]     s_tdata   = '0;   // delta_time
    logic [FUNC_W-1:0]     s_tuser   = '0;   // func
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_W-1:0]        m_tdata;          // color [31:0], glow [48:32], phase [50:49]

    always #HALF_PERIOD aclk = ~aclk;

    fade_blink_light_sequencer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Sequencer model: registers and state, updated on each accepted beat
    // ------------------------------------------------------------------
    logic [TIME_W-1:0]  fade_ticks_r, blink_period_r;
    logic [COLOR_W-1:0] rest_color_r, lit_color_r;
    phase_t             ph_r;
    logic [TIME_W-1:0]  fade_timer_r, blink_pos_r;
    logic [COLOR_W-1:0] color_r, color_from_r;
    logic [GLOW_W-1:0]  glow_r, glow_from_r;

    light_t    due_lights[$];     // results owed by the block, oldest first
    stim_row_t directed_rows[$];
    int        mismatches   = 0;
    int        results_seen = 0;
    int        burst_left;

    // Q1.16 fraction elapsed/span, saturating at one
    function automatic logic [GLOW_W-1:0] fade_fraction(logic [TIME_W-1:0] elapsed,
                                                        logic [TIME_W-1:0] span);
        if (elapsed >= span)
            return Q_ONE;
        return 17'({elapsed, 16'h0} / span);
    endfunction

    // a*(1-t) + b*t, rounded half up
    function automatic logic [GLOW_W-1:0] mix_q(logic [GLOW_W-1:0] a, logic [GLOW_W-1:0] b,
                                                logic [GLOW_W-1:0] t);
        logic [63:0] acc;
        acc = 64'(a) * (64'(Q_ONE) - 64'(t)) + 64'(b) * 64'(t) + 64'(Q_HALF);
        return acc[32:16];
    endfunction

    function automatic logic [COLOR_W-1:0] mix_rgba(logic [COLOR_W-1:0] a,
                                                    logic [COLOR_W-1:0] b,
                                                    logic [GLOW_W-1:0] t);
        logic [COLOR_W-1:0] r;
        logic [GLOW_W-1:0]  c;
        r = '0;
        for (int k = 0; k < NUM_CHAN; k++) begin
            c = mix_q(17'(a[k*CHAN_W +: CHAN_W]), 17'(b[k*CHAN_W +: CHAN_W]), t);
            r[k*CHAN_W +: CHAN_W] = c[CHAN_W-1:0];
        end
        return r;
    endfunction

    function automatic light_t step_sequencer(logic [FUNC_W-1:0] fn, logic [TIME_W-1:0] dt);
        logic [GLOW_W-1:0] t;
        logic [GLOW_W-1:0] u;
        logic [16:0]       sum;
        logic [TIME_W-1:0] per;
        light_t            res;
        case (fn)
            FN_TICK: begin
                if (ph_r == PH_IN || ph_r == PH_OUT) begin
                    sum = 17'(fade_timer_r) + 17'(dt);
                    fade_timer_r = sum[16] ? 16'hFFFF : sum[15:0];   // saturate
                    t = fade_fraction(fade_timer_r, fade_ticks_r);
                    if (ph_r == PH_IN) begin
                        color_r = mix_rgba(color_from_r, lit_color_r, t);
                        glow_r  = mix_q(glow_from_r, Q_ONE, t);
                    end else begin
                        color_r = mix_rgba(color_from_r, rest_color_r, t);
                        glow_r  = mix_q(glow_from_r, '0, t);
                    end
                    if (t == Q_ONE) begin
                        if (ph_r == PH_IN) begin
                            ph_r = PH_BLINK;
                            blink_pos_r = '0;   // completing tick does not blink
                        end else begin
                            ph_r = PH_IDLE;
                        end
                    end
                end else if (ph_r == PH_BLINK) begin
                    // period zero behaves as one: glow pinned at zero
                    per = (blink_period_r == '0) ? 16'd1 : blink_period_r;
                    blink_pos_r = 16'((17'(blink_pos_r) + 17'(dt)) % 17'(per));
                    u = fade_fraction(blink_pos_r, per);
                    glow_r = (u < Q_HALF) ? 17'(u << 1) : 17'(18'h20000 - (18'(u) << 1));
                end
            end
            FN_BEGIN: begin
                if (ph_r == PH_IDLE || ph_r == PH_OUT) begin
                    fade_timer_r = '0;
                    ph_r = PH_IN;
                    color_from_r = color_r;
                    glow_from_r  = glow_r;
                end
            end
            FN_END: begin
                if (ph_r == PH_IN || ph_r == PH_BLINK) begin
                    fade_timer_r = '0;
                    ph_r = PH_OUT;
                    color_from_r = color_r;
                    glow_from_r  = glow_r;
                end
            end
            default: ;
        endcase
        res.color = color_r;
        res.glow  = glow_r;
        res.ph    = ph_r;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("%0t mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Source side: beats in bursts, valid held across back-to-back beats
    // ------------------------------------------------------------------
    task automatic pause_input(int gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_beat(logic [FUNC_W-1:0] fn, logic [TIME_W-1:0] dt,
                             bit typed, light_t want);
        light_t model_out;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= fn;
        s_tdata  <= dt;
        do @(posedge aclk); while (!s_tready);
        model_out = step_sequencer(fn, dt);
        due_lights.push_back(typed ? want : model_out);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            // mostly short gaps, now and then a longer one
            pause_input(($urandom_range(0, 3) == 0) ? $urandom_range(8, 45)
                                                    : $urandom_range(0, 4));
            burst_left = $urandom_range(1, 24);
        end
    endtask

    // registers change only with nothing in flight
    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        if (s_tvalid)
            pause_input(1);
        while (due_lights.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_FADE_TICKS:   fade_ticks_r   = val[TIME_W-1:0];
            CFG_BLINK_PERIOD: blink_period_r = val[TIME_W-1:0];
            CFG_REST_COLOR:   rest_color_r   = val;
            default:          lit_color_r    = val;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(logic [TIME_W-1:0] ft, logic [TIME_W-1:0] bp,
                                 logic [COLOR_W-1:0] rest, logic [COLOR_W-1:0] lit);
        write_register(CFG_FADE_TICKS, 32'(ft));
        write_register(CFG_BLINK_PERIOD, 32'(bp));
        write_register(CFG_REST_COLOR, rest);
        write_register(CFG_LIT_COLOR, lit);
    endtask

    // Commands are drawn by phase so most traffic drives full begin/fade/
    // blink/end cycles; the rest is redundant events and the unused code.
    task automatic run_random(int beats);
        int                done_beats;
        int                pick;
        int                span;
        bit                effective;
        logic [FUNC_W-1:0] fn;
        logic [TIME_W-1:0] dt;
        light_t            none;
        done_beats = 0;
        none = '{32'h0, 17'h0, PH_IDLE};
        while (done_beats < beats) begin
            pick = $urandom_range(0, 99);
            case (ph_r)
                PH_IDLE:  fn = (pick < 80) ? FN_BEGIN : (pick < 88) ? FN_TICK :
                               (pick < 94) ? FN_END : FN_NONE;
                PH_IN:    fn = (pick < 78) ? FN_TICK : (pick < 88) ? FN_END :
                               (pick < 94) ? FN_BEGIN : FN_NONE;
                PH_BLINK: fn = (pick < 75) ? FN_TICK : (pick < 93) ? FN_END :
                               (pick < 97) ? FN_BEGIN : FN_NONE;
                default:  fn = (pick < 75) ? FN_TICK : (pick < 90) ? FN_BEGIN :
                               (pick < 96) ? FN_END : FN_NONE;
            endcase
            // delta sized so a fade ends in a few ticks and blinks wrap
            span = (ph_r == PH_BLINK) ? 2 * int'(blink_period_r) : int'(fade_ticks_r) / 3;
            span = (span + 1 > 65535) ? 65535 : span + 1;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                dt = 16'hFFFF;
            else if (pick < 14)
                dt = '0;
            else if (pick < 30)
                dt = 16'($urandom);
            else
                dt = 16'($urandom_range(0, span));
            effective = (fn == FN_TICK && ph_r != PH_IDLE) ||
                        (fn == FN_BEGIN && (ph_r == PH_IDLE || ph_r == PH_OUT)) ||
                        (fn == FN_END && (ph_r == PH_IN || ph_r == PH_BLINK));
            send_beat(fn, dt, 1'b0, none);
            if (effective)
                done_beats++;
        end
    endtask

    // directed table builders
    task automatic add_beat(logic [FUNC_W-1:0] fn, logic [TIME_W-1:0] dt);
        directed_rows.push_back('{1'b0, CFG_FADE_TICKS, '0, fn, dt, 1'b0,
                                  '{32'h0, 17'h0, PH_IDLE}});
    endtask

    task automatic add_known(logic [FUNC_W-1:0] fn, logic [TIME_W-1:0] dt,
                             logic [COLOR_W-1:0] color, logic [GLOW_W-1:0] glow, phase_t ph);
        directed_rows.push_back('{1'b0, CFG_FADE_TICKS, '0, fn, dt, 1'b1,
                                  '{color, glow, ph}});
    endtask

    task automatic add_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        directed_rows.push_back('{1'b1, idx, val, FN_TICK, '0, 1'b0,
                                  '{32'h0, 17'h0, PH_IDLE}});
    endtask

    // ------------------------------------------------------------------
    // Stimulus: reset, directed table, random phases, drain
    // ------------------------------------------------------------------
    initial begin
        fade_ticks_r   = 16'd1000;
        blink_period_r = 16'd1000;
        rest_color_r   = '0;
        lit_color_r    = 32'hFFFF_FFFF;
        ph_r           = PH_IDLE;
        fade_timer_r   = '0;
        blink_pos_r    = '0;
        color_r        = '0;
        color_from_r   = '0;
        glow_r         = '0;
        glow_from_r    = '0;
        burst_left     = $urandom_range(1, 24);

        // reset-state registers: fade 1000, period 1000, rest 0, lit all ones
        add_known(FN_TICK,  16'hFFFF, 32'h0, 17'h0, PH_IDLE);            // tick while idle
        add_known(FN_NONE,  16'hFFFF, 32'h0, 17'h0, PH_IDLE);            // unused code
        add_known(FN_END,   16'h0000, 32'h0, 17'h0, PH_IDLE);            // end while idle
        add_known(FN_BEGIN, 16'h0000, 32'h0, 17'h0, PH_IN);
        add_known(FN_BEGIN, 16'h1234, 32'h0, 17'h0, PH_IN);              // begin while fading in
        add_beat(FN_TICK, 16'd500);                                      // halfway
        add_known(FN_TICK, 16'hFFFF, 32'hFFFF_FFFF, Q_ONE, PH_BLINK);    // timer saturates
        add_known(FN_BEGIN, 16'h0000, 32'hFFFF_FFFF, Q_ONE, PH_BLINK);   // begin while blinking
        add_known(FN_TICK, 16'h0000, 32'hFFFF_FFFF, 17'h0, PH_BLINK);
        add_beat(FN_TICK, 16'd500);                                      // triangle peak
        add_beat(FN_TICK, 16'd1250);                                     // wraps the period
        add_beat(FN_END, 16'h0000);
        add_beat(FN_END, 16'hFFFF);                                      // end while fading out
        add_beat(FN_TICK, 16'd300);
        add_beat(FN_BEGIN, 16'h0000);                                    // reverse mid fade out
        add_known(FN_TICK, 16'hFFFF, 32'hFFFF_FFFF, Q_ONE, PH_BLINK);
        add_known(FN_END, 16'h0000, 32'hFFFF_FFFF, Q_ONE, PH_OUT);
        add_known(FN_TICK, 16'hFFFF, 32'h0, 17'h0, PH_IDLE);
        // zero fade length and zero blink period
        add_write(CFG_FADE_TICKS, 32'h0);
        add_write(CFG_BLINK_PERIOD, 32'h0);
        add_known(FN_BEGIN, 16'h0000, 32'h0, 17'h0, PH_IN);
        add_known(FN_TICK, 16'h0000, 32'hFFFF_FFFF, Q_ONE, PH_BLINK);
        add_known(FN_TICK, 16'd777, 32'hFFFF_FFFF, 17'h0, PH_BLINK);
        add_known(FN_END, 16'h0000, 32'hFFFF_FFFF, 17'h0, PH_OUT);
        add_known(FN_TICK, 16'h0000, 32'h0, 17'h0, PH_IDLE);

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_write)
                write_register(directed_rows[i].idx, directed_rows[i].val);
            else
                send_beat(directed_rows[i].fn, directed_rows[i].dt,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        // register settings: both extremes, the zero corner, small and wide values, a fixed mix
        apply_setting(16'd1, 16'd1, $urandom, $urandom);
        run_random(RANDOM_BEATS);
        apply_setting(16'hFFFF, 16'hFFFF, 32'h0, 32'hFFFF_FFFF);
        run_random(RANDOM_BEATS);
        apply_setting(16'd0, 16'd0, $urandom, $urandom);
        run_random(RANDOM_BEATS);
        apply_setting(16'($urandom_range(2, 64)), 16'($urandom_range(2, 64)),
                      $urandom, $urandom);
        run_random(RANDOM_BEATS);
        apply_setting(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                      $urandom, $urandom);
        run_random(RANDOM_BEATS);
        apply_setting(16'd37, 16'd1000, 32'hFFFF_FFFF, 32'h0);
        run_random(RANDOM_BEATS);

        pause_input(1);
        while (due_lights.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sink side: ready pattern changes mode at random intervals; one
    // long hold lets the output register and the in-flight beat back up
    // into s_tready while the source keeps offering.
    // ------------------------------------------------------------------
    initial begin
        ready_mode_t mode;
        int          mode_left;
        bit          held;
        mode      = READY_ALWAYS;
        mode_left = 0;
        held      = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if (mode_left == 0) begin
                mode      = ready_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 256);
            end
            mode_left--;
            case (mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_COIN:   m_tready <= 1'($urandom_range(0, 1));
                READY_MOSTLY: m_tready <= ($urandom_range(0, 9) != 0);
                default:      m_tready <= ((mode_left % 5) > 1);
            endcase
        end
    end

    // result checker: one beat per accepted m_ handshake, field by field
    initial begin
        light_t head;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                results_seen++;
                if (due_lights.size() == 0) begin
                    report_mismatch("unexpected beat, color", m_tdata[31:0], 32'h0);
                end else begin
                    head = due_lights.pop_front();
                    if (m_tdata[31:0] !== head.color)
                        report_mismatch("color_out", m_tdata[31:0], head.color);
                    if (m_tdata[48:32] !== head.glow)
                        report_mismatch("glow_out", 32'(m_tdata[48:32]), 32'(head.glow));
                    if (m_tdata[50:49] !== head.ph)
                        report_mismatch("phase_out", 32'(m_tdata[50:49]), 32'(head.ph));
                end
            end
        end
    end

    // watchdog: ends the run when no channel has moved for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
rtl/fbls_pkg.sv
rtl/fbls_div.sv
rtl/fbls_lerp.sv
rtl/fade_blink_light_sequencer.sv
tb/fade_blink_light_sequencer_tb.sv
